FILE: rtl/core/bds_pkg.sv
// Package for the descending distinct-value sorter.
// Holds the sizing constants, the action codes and the bitmap command type.
// No dependencies.
`default_nettype none

package bds_pkg;

   localparam int VALUE_RANGE = 4096;
   localparam int VALUE_W     = 12;
   localparam int WORD_BITS   = 64;
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int WORD_COUNT  = (VALUE_RANGE + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int PTR_W       = $clog2(VALUE_RANGE + 1);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [WORD_AW-1:0]   waddr_type;
   typedef logic [BIT_W-1:0]     bitpos_type;
   typedef logic [PTR_W-1:0]     ptr_type;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_PULL   = 2'd2
   } action_type;

   typedef struct packed {
      logic      clear;
      logic      rd_en;
      waddr_type rd_addr;
      logic      wr_en;
      waddr_type wr_addr;
      word_type  wr_data;
   } mem_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/core/bds_if.sv
// Request and response channel interfaces of the descending sorter.
// Depends on bds_pkg for the field widths.
`default_nettype none

interface bds_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   action;
   logic [bds_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface bds_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bds_pkg::VALUE_W-1:0]  out_value;
   logic                         found;
   logic                         was_present;

   modport source (output valid, output out_value, output found, output was_present,
                   input ready);
   modport sink   (input valid, input out_value, input found, input was_present,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bds_bitmap.sv
// Presence bitmap: one 64-bit word per row, one read and one write port.
// Rows carry valid bits so that a clear need not rewrite the rows. Uses bds_pkg.
`default_nettype none

module bds_bitmap (
   input  logic                 clock,
   input  logic                 reset,
   input  bds_pkg::mem_cmd_type cmd,
   output bds_pkg::word_type    rd_data
);
   import bds_pkg::*;

   word_type                mem [WORD_COUNT];
   logic [WORD_COUNT-1:0]   row_valid_ff;
   word_type                rd_word_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_word_ff <= mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (cmd.clear) begin
            row_valid_ff <= '0;
         end else if (cmd.wr_en) begin
            row_valid_ff[cmd.wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= row_valid_ff[cmd.rd_addr];
         end
      end
   end

   // A row never written since the last clear reads as all zero.
   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> row_valid_ff == '0)
      else $error("bitmap rows still valid after a clear");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_en && (cmd.rd_en || cmd.clear)))
      else $error("bitmap write issued together with a read or clear");

   a_clear_alone: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear && cmd.rd_en))
      else $error("bitmap read issued together with a clear");

endmodule

`default_nettype wire

FILE: rtl/core/bds_prienc.sv
// Priority encoder over one bitmap word: finds the highest set bit.
// Uses bds_pkg for the word and bit position types.
`default_nettype none

module bds_prienc (
   input  bds_pkg::word_type   word,
   output logic                hit,
   output bds_pkg::bitpos_type index
);
   import bds_pkg::*;

   always_comb begin
      index = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (word[i]) begin
            index = BIT_W'(i);
         end
      end
   end

   assign hit = |word;

endmodule

`default_nettype wire

FILE: rtl/core/bitmap_distinct_descending_sort.sv
// Descending distinct-value sorter, top level.
// Depends on bds_pkg, the channel interfaces, bds_bitmap and bds_prienc.
//
// Requests arrive on req_bus (valid/ready) with an action and a value.
// A clear empties the presence bitmap and rewinds the scan pointer to the
// top of the value range. An insert marks its value present, reports in
// was_present whether it was already marked, and rewinds the pointer. A pull
// returns the next present value below the pointer with found set, or found
// clear once no value is left, so repeated pulls give the distinct values in
// descending order. Every request produces exactly one response on rsp_bus.
// The block handles one request at a time. A clear goes straight from
// acceptance to the response; an insert first reads the bitmap word and then
// writes it back. A pull scans the 64-bit bitmap words downward until a hit
// or the bottom of the range; the single bitmap read port and the shared
// priority encoder examine one word per cycle, over at most 64 words.
// Without stalls the next request is taken at the edge where the response can
// first be taken.
// The response sits in an output register; a new request is taken while it
// waits, and a finished result holds back until the receiver takes the
// previous one. Reset empties the bitmap through per-word valid bits.
`default_nettype none

module bitmap_distinct_descending_sort (
   input  logic   clock,
   input  logic   reset,
   bds_req_if.sink   req_bus,
   bds_rsp_if.source rsp_bus
);
   import bds_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INS_WR,
      ST_SCAN,
      ST_RESP
   } state_type;

   state_type          state_ff;
   ptr_type            ptr_ff;
   waddr_type          word_ff;
   bitpos_type         bitpos_ff;
   word_type           mask_ff;

   // Result waiting to be moved into the response register.
   logic [VALUE_W-1:0] res_value_ff;
   logic               res_found_ff;
   logic               res_present_ff;

   // Response register.
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_found_ff;
   logic               rsp_present_ff;

   mem_cmd_type        cmd;
   word_type           rd_data;
   word_type           masked;
   logic               hit;
   bitpos_type         hit_index;

   logic               accept;
   logic               ins_in_range;
   ptr_type            scan_top;
   ptr_type            scan_start;
   waddr_type          start_word;
   bitpos_type         start_bit;
   logic               rsp_free;
   logic               rsp_load;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign ins_in_range  = (32'(req_bus.value) < 32'(VALUE_RANGE));

   // The pull starts one below the pointer, which never exceeds the range.
   assign scan_top   = (ptr_ff > PTR_W'(VALUE_RANGE)) ? PTR_W'(VALUE_RANGE) : ptr_ff;
   assign scan_start = scan_top - PTR_W'(1);
   assign start_word = WORD_AW'(scan_start >> BIT_W);
   assign start_bit  = scan_start[BIT_W-1:0];

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   // A finished result moves into the response register once it is free.
   assign rsp_load = (state_ff == ST_RESP) && rsp_free;

   bds_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   assign masked = rd_data & mask_ff;

   bds_prienc u_prienc (
      .word  (masked),
      .hit   (hit),
      .index (hit_index)
   );

   // Bitmap commands follow from the state and the request being taken.
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_bus.action == ACT_CLEAR) begin
                  cmd.clear = 1'b1;
               end else if (req_bus.action == ACT_INSERT && ins_in_range) begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = WORD_AW'(req_bus.value >> BIT_W);
               end else if (req_bus.action == ACT_PULL && scan_top != '0) begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = start_word;
               end
            end
         end
         ST_INS_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = word_ff;
            cmd.wr_data = rd_data | (word_type'(1) << bitpos_ff);
         end
         ST_SCAN: begin
            // Fetch the next lower word while this one is examined.
            if (!hit && word_ff != '0) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = word_ff - WORD_AW'(1);
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= PTR_W'(VALUE_RANGE);
         rsp_valid_ff <= 1'b0;
      end else begin
         // The response register fills from a finished result and empties
         // when the receiver takes it.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  res_value_ff   <= '0;
                  res_found_ff   <= 1'b0;
                  res_present_ff <= 1'b0;
                  if (req_bus.action == ACT_CLEAR) begin
                     ptr_ff   <= PTR_W'(VALUE_RANGE);
                     state_ff <= ST_RESP;
                  end else if (req_bus.action == ACT_INSERT) begin
                     ptr_ff    <= PTR_W'(VALUE_RANGE);
                     word_ff   <= WORD_AW'(req_bus.value >> BIT_W);
                     bitpos_ff <= req_bus.value[BIT_W-1:0];
                     if (ins_in_range) begin
                        state_ff <= ST_INS_WR;
                     end else begin
                        state_ff <= ST_RESP;
                     end
                  end else if (req_bus.action == ACT_PULL) begin
                     if (scan_top == '0) begin
                        ptr_ff   <= '0;
                        state_ff <= ST_RESP;
                     end else begin
                        word_ff  <= start_word;
                        mask_ff  <= {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - start_bit);
                        state_ff <= ST_SCAN;
                     end
                  end else begin
                     // The unused action code only produces an all-zero response.
                     state_ff <= ST_RESP;
                  end
               end
            end
            ST_INS_WR: begin
               res_present_ff <= rd_data[bitpos_ff];
               state_ff       <= ST_RESP;
            end
            ST_SCAN: begin
               mask_ff <= {WORD_BITS{1'b1}};
               if (hit) begin
                  res_value_ff <= VALUE_W'({word_ff, hit_index});
                  res_found_ff <= 1'b1;
                  ptr_ff       <= PTR_W'({word_ff, hit_index});
                  state_ff     <= ST_RESP;
               end else if (word_ff == '0) begin
                  ptr_ff   <= '0;
                  state_ff <= ST_RESP;
               end else begin
                  word_ff <= word_ff - WORD_AW'(1);
               end
            end
            ST_RESP: begin
               if (rsp_load) begin
                  rsp_value_ff   <= res_value_ff;
                  rsp_found_ff   <= res_found_ff;
                  rsp_present_ff <= res_present_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_value   = rsp_value_ff;
   assign rsp_bus.found       = rsp_found_ff;
   assign rsp_bus.was_present = rsp_present_ff;

   a_found_not_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_present_ff))
      else $error("response flags both a found pull and a present insert");

   a_miss_parks_pointer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !hit && word_ff == '0) |=> ptr_ff == '0)
      else $error("exhausted pull did not park the pointer at zero");

   a_hit_sets_pointer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && hit) |=> (res_found_ff && ptr_ff == PTR_W'(res_value_ff)))
      else $error("pointer does not match the value returned by a pull");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the descending distinct-value sorter.
// It depends on bds_pkg, the channel interfaces in bds_if.sv and the top level
// bitmap_distinct_descending_sort. It holds its own bitmap predictor.
`timescale 1ns / 100ps

module testbench;
   import bds_pkg::*;

   // The package has no name for action code 3. The block must answer it with
   // an all-zero response and must leave its state alone.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // A full miss scans every word of the bitmap, and each request may also wait
   // out a sender gap and receiver stalls. The limit is several times the
   // slowest correct run.
   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_TICKS = 80;

   typedef struct packed {
      logic [VALUE_W-1:0] out_value;
      logic               found;
      logic               was_present;
   } sort_result_type;

   logic clock;
   logic reset;

   bds_req_if req_bus ();
   bds_rsp_if rsp_bus ();

   bitmap_distinct_descending_sort u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predictor state. It is kept apart from the block: one presence bit per
   // value, and a scan pointer that can also hold the top of the range.
   bit [VALUE_RANGE-1:0] presence_map;
   ptr_type              scan_ptr;

   sort_result_type expected_results[$];
   int              error_count;
   int              requests_sent;
   int              burst_left;
   int              cycle_count;

   // Receiver stall pattern. The mode is drawn anew whenever stall_tick wraps to
   // zero. Mode 0 never stalls, mode 1 stalls at random, and mode 2 follows a rotating bit mask.
   int        stall_mode;
   int        stall_tick;
   logic [7:0] stall_mask;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Work out the response to one request and update the predictor state.
   // This follows the block's rules:
   //  - A clear empties the bitmap and rewinds the pointer to the top.
   //  - An insert rewinds the pointer even when its value is out of range.
   //  - A pull searches downward from just below the pointer. When nothing
   //    is left, the pointer parks at zero, so later pulls stay exhausted.
   function automatic sort_result_type predict_sorted_value(logic [1:0] act,
                                                            logic [VALUE_W-1:0] val);
      sort_result_type res;
      ptr_type         pos;
      bit              hit;
      res = '0;
      hit = 1'b0;
      case (act)
         ACT_CLEAR: begin
            presence_map = '0;
            scan_ptr     = ptr_type'(VALUE_RANGE);
         end
         ACT_INSERT: begin
            if (int'(val) < VALUE_RANGE) begin
               res.was_present   = presence_map[val];
               presence_map[val] = 1'b1;
            end
            scan_ptr = ptr_type'(VALUE_RANGE);
         end
         ACT_PULL: begin
            pos = (int'(scan_ptr) > VALUE_RANGE) ? ptr_type'(VALUE_RANGE) : scan_ptr;
            while (pos > 0 && !hit) begin
               pos = pos - 1'b1;
               if (presence_map[pos]) begin
                  hit           = 1'b1;
                  res.out_value = pos[VALUE_W-1:0];
                  res.found     = 1'b1;
                  scan_ptr      = pos;
               end
            end
            if (!hit) begin
               scan_ptr = '0;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Send one request. The call starts just after a falling edge and returns
   // just after the next falling edge once the request has been accepted.
   // Requests go out in bursts. Between bursts the sender idles for a random
   // gap, which is sometimes zero, so that back-to-back stretches occur too.
   // Valid stays high from one request to the next inside a burst.
   task automatic send_request(input logic [1:0] act, input logic [VALUE_W-1:0] val);
      int idle;
      if (burst_left == 0) begin
         idle = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
         if (idle > 0) begin
            req_bus.valid = 1'b0;
            repeat (idle) @(negedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      req_bus.valid  = 1'b1;
      req_bus.action = act;
      req_bus.value  = val;
      do @(posedge clock); while (!req_bus.ready);
      expected_results = {expected_results, predict_sorted_value(act, val)};
      burst_left    = burst_left - 1;
      requests_sent = requests_sent + 1;
      @(negedge clock);
   endtask

   // Hold off the sender until every outstanding response has come back.
   task automatic wait_for_drain();
      req_bus.valid = 1'b0;
      burst_left    = 0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   // Directed requests. They cover the field extremes, every action, the
   // unused code, duplicate inserts, word boundaries, and pulls past the
   // end of the sequence both before and after a clear.
   task automatic test_directed_cases();
      send_request(ACT_PULL, 12'h000);
      send_request(ACT_INSERT, 12'h000);
      send_request(ACT_INSERT, 12'hFFF);
      send_request(ACT_INSERT, 12'hFFF);
      send_request(ACT_INSERT, 12'h800);
      send_request(ACT_INSERT, 12'hAAA);
      send_request(ACT_INSERT, 12'h555);
      send_request(ACT_INSERT, 12'd63);
      send_request(ACT_INSERT, 12'd64);
      repeat (8) send_request(ACT_PULL, 12'hFFF);
      send_request(ACT_PULL, 12'h000);
      send_request(ACT_UNUSED, 12'hFFF);
      send_request(ACT_INSERT, 12'h555);
      send_request(ACT_PULL, 12'h000);
      send_request(ACT_CLEAR, 12'hFFF);
      send_request(ACT_PULL, 12'h000);
      send_request(ACT_INSERT, 12'd1);
      send_request(ACT_PULL, 12'h000);
      wait_for_drain();
   endtask

   // Well-formed sorting runs make up most of the traffic. Each run clears
   // the bitmap, inserts a set of values, and then pulls them back in
   // descending order until the set is exhausted. The value mix changes from
   // run to run. It may be spread over the whole range, packed into a narrow
   // window so that duplicates are common, held low so that pulls scan many
   // empty words, or drawn from edge values. Some runs skip the clear, and
   // some insert again partway through the pulls, which rewinds the pointer.
   task automatic test_sort_sequences(input int target);
      int                  count;
      int                  mix;
      int                  base;
      int                  pulls;
      logic [VALUE_W-1:0]  val;
      while (requests_sent < target) begin
         if ($urandom_range(0, 4) != 0) begin
            send_request(ACT_CLEAR, VALUE_W'($urandom));
         end
         count = $urandom_range(1, 24);
         mix   = $urandom_range(0, 3);
         base  = $urandom_range(0, 4095 - 15);
         for (int i = 0; i < count; i++) begin
            case (mix)
               0: val = VALUE_W'($urandom);
               1: val = VALUE_W'(base + $urandom_range(0, 15));
               2: val = VALUE_W'($urandom_range(0, 127));
               default: begin
                  case ($urandom_range(0, 5))
                     0: val = 12'h000;
                     1: val = 12'hFFF;
                     2: val = 12'd63;
                     3: val = 12'd64;
                     4: val = 12'h7FF;
                     default: val = 12'h800;
                  endcase
               end
            endcase
            send_request(ACT_INSERT, val);
         end
         // Sometimes the pulls start only after the block has gone quiet.
         if ($urandom_range(0, 7) == 0) begin
            wait_for_drain();
         end
         pulls = count + $urandom_range(0, 2);
         for (int i = 0; i < pulls; i++) begin
            if (i == count / 2 && $urandom_range(0, 4) == 0) begin
               send_request(ACT_INSERT, VALUE_W'($urandom));
            end
            send_request(ACT_PULL, VALUE_W'($urandom));
         end
      end
      wait_for_drain();
   endtask

   // Unstructured requests with every action code, including the unused one.
   // Clears are made rarer so that the bitmap fills up between them.
   task automatic test_mixed_noise(input int count);
      logic [1:0] act;
      for (int i = 0; i < count; i++) begin
         act = 2'($urandom_range(0, 3));
         if (act == ACT_CLEAR && $urandom_range(0, 3) != 0) begin
            act = ACT_INSERT;
         end
         send_request(act, VALUE_W'($urandom));
      end
      wait_for_drain();
   endtask

   // The receiver drives ready at the falling edge with its own stall pattern.
   always @(negedge clock) begin
      if (stall_tick == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_mask = 8'($urandom_range(1, 255));
      end
      stall_tick = (stall_tick + 1) % 64;
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         default: begin
            rsp_bus.ready <= stall_mask[0];
            stall_mask     = {stall_mask[0], stall_mask[7:1]};
         end
      endcase
   end

   task automatic report_field(input string field, input int expected, input int actual);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
      error_count = error_count + 1;
   endtask

   // Each accepted response is checked field by field against the oldest
   // expected result.
   always @(posedge clock) begin
      sort_result_type exp_res;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $display({"%0t: unexpected response, expected none, ",
                      "actual out_value %0d found %0b was_present %0b"},
                     $time, rsp_bus.out_value, rsp_bus.found, rsp_bus.was_present);
            error_count = error_count + 1;
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_bus.out_value !== exp_res.out_value)
               report_field("out_value", exp_res.out_value, rsp_bus.out_value);
            if (rsp_bus.found !== exp_res.found)
               report_field("found", exp_res.found, rsp_bus.found);
            if (rsp_bus.was_present !== exp_res.was_present)
               report_field("was_present", exp_res.was_present, rsp_bus.was_present);
         end
      end
   end

   // The watchdog ends a run that hangs.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  expected_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The main sequence resets the block once, runs each test in turn, waits
   // for the last response plus some settle time, and reports the result.
   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.action = ACT_CLEAR;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;
      presence_map   = '0;
      scan_ptr       = ptr_type'(VALUE_RANGE);
      error_count    = 0;
      requests_sent  = 0;
      burst_left     = 0;
      cycle_count    = 0;
      stall_mode     = 0;
      stall_tick     = 0;
      stall_mask     = 8'hFF;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_sort_sequences(680);
      test_mixed_noise(150);

      wait_for_drain();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
